>>> src/dnms_pkg.sv
`default_nettype none

package dnms_pkg;

	// Line buffer geometry and field widths
	localparam int MAX_WIDTH  = 1024;
	localparam int MAG_BITS   = 16;
	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int W_BITS     = COL_BITS + 1;
	localparam int ROW_BITS   = 12;
	localparam int DIR_BITS   = 3;
	localparam int MIN_DIM    = 3;

	// Configuration port
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 12;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;
	localparam logic [W_BITS-1:0]   WIDTH_RESET  = W_BITS'(640);
	localparam logic [ROW_BITS-1:0] HEIGHT_RESET = ROW_BITS'(480);

	// Direction codes; any other code means no direction
	localparam logic [DIR_BITS-1:0] DIR_H    = 3'd0;
	localparam logic [DIR_BITS-1:0] DIR_D45  = 3'd1;
	localparam logic [DIR_BITS-1:0] DIR_V    = 3'd2;
	localparam logic [DIR_BITS-1:0] DIR_D135 = 3'd3;

	typedef struct packed {
		logic                frame_start;
		logic                candidate;
		logic [MAG_BITS-1:0] magnitude;
		logic [DIR_BITS-1:0] direction;
	} pix_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] out_row;
		logic [COL_BITS-1:0] out_col;
		logic                edge_res;
		logic                last_pixel;
	} res_t;

	typedef struct packed {
		logic                candidate;
		logic [DIR_BITS-1:0] direction;
	} tag_t;

	// One line buffer entry: previous row, row before that, previous row's tag
	typedef struct packed {
		logic [MAG_BITS-1:0] mag_a;
		logic [MAG_BITS-1:0] mag_b;
		tag_t                tag;
	} line_word_t;

	// Pixel held between the input register and the result register
	typedef struct packed {
		logic                active;
		logic                emit;
		logic                last;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] out_row;
		logic [COL_BITS-1:0] out_col;
		logic [MAG_BITS-1:0] mag;
		tag_t                tag;
	} stage_t;

endpackage

`default_nettype wire

>>> src/directional_nonmax_suppression.sv
`default_nettype none

// Channel  | Signals                        | Moves
// pix      | pix_valid, pix_stall, pix      | one pixel per transaction
// res      | res_valid, res_stall, res      | one interior centre result
// cfg      | cfg_write, cfg_index, cfg_data | register write, no handshake
//
// One pixel per cycle while pix_stall is low; a result is loaded when its held pixel commits.
// Latency is set by the registered line buffer read and the result register.
// Reset clears counters, window and control; line buffers need no clearing.
// A stalled result still lets one more pixel in; pix_stall rises only while
// the result register is full and stalled and the held pixel has a result.
module directional_nonmax_suppression (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [dnms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [dnms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  dnms_pkg::pix_t                     pix,
	output logic                               res_valid,
	input  logic                               res_stall,
	output dnms_pkg::res_t                     res
);
	import dnms_pkg::*;

	logic                accept, commit, res_free;
	logic [COL_BITS-1:0] rd_addr;
	stage_t              stage_s1;
	line_word_t          rd_word, wr_data;

	dnms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_free  (res_free),
		.accept    (accept),
		.commit    (commit),
		.rd_addr   (rd_addr),
		.stage_s1  (stage_s1)
	);

	// New entry: this pixel, the row above moves down, this pixel's tag
	assign wr_data = '{mag_a: stage_s1.mag, mag_b: rd_word.mag_a, tag: stage_s1.tag};

	dnms_linebuf u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr_en   (commit && stage_s1.active),
		.wr_addr (stage_s1.col),
		.wr_data (wr_data),
		.rd_word (rd_word)
	);

	dnms_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.stage_s1  (stage_s1),
		.rd_word   (rd_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.res_free  (res_free)
	);

endmodule

`default_nettype wire

>>> src/dnms_ctrl.sv
`default_nettype none

module dnms_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [dnms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [dnms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  dnms_pkg::pix_t                     pix,
	input  logic                               res_free,
	output logic                               accept,
	output logic                               commit,
	output logic [dnms_pkg::COL_BITS-1:0]      rd_addr,
	output dnms_pkg::stage_t                   stage_s1
);
	import dnms_pkg::*;

	logic [W_BITS-1:0]   width_q;
	logic [ROW_BITS-1:0] height_q;
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic                valid_s1;

	logic [COL_BITS-1:0] c_start, c_cur, col_next;
	logic [ROW_BITS-1:0] r_cur, row_next;
	logic [W_BITS-1:0]   c_inc;
	logic                act, col_wrap;
	logic [W_BITS-1:0]   w_val;
	logic [ROW_BITS-1:0] h_val;
	stage_t              stage_d;

	// Clamp register writes to the supported frame size
	always_comb begin
		w_val = cfg_data[W_BITS-1:0];
		if (w_val < W_BITS'(MIN_DIM))
			w_val = W_BITS'(MIN_DIM);
		else if (w_val > W_BITS'(MAX_WIDTH))
			w_val = W_BITS'(MAX_WIDTH);
		// the 12-bit height field cannot exceed the top of the range
		h_val = cfg_data[ROW_BITS-1:0];
		if (h_val < ROW_BITS'(MIN_DIM))
			h_val = ROW_BITS'(MIN_DIM);
	end

	// Position of the incoming pixel and the counters that follow it
	always_comb begin
		c_start  = pix.frame_start ? '0 : col_q;
		r_cur    = pix.frame_start ? '0 : row_q;
		c_cur    = ({1'b0, c_start} >= width_q) ? '0 : c_start;
		c_inc    = {1'b0, c_cur} + W_BITS'(1);
		act      = r_cur < height_q;
		col_wrap = c_inc >= width_q;
		col_next = col_wrap ? '0 : c_inc[COL_BITS-1:0];
		row_next = (act && col_wrap) ? r_cur + ROW_BITS'(1) : r_cur;

		stage_d.active  = act;
		stage_d.emit    = act && (r_cur >= ROW_BITS'(2)) && (c_cur >= COL_BITS'(2));
		stage_d.last    = (r_cur == height_q - ROW_BITS'(1))
			&& ({1'b0, c_cur} == width_q - W_BITS'(1));
		stage_d.col     = c_cur;
		stage_d.out_row = r_cur - ROW_BITS'(1);
		stage_d.out_col = c_cur - COL_BITS'(1);
		stage_d.mag     = pix.magnitude;
		stage_d.tag     = '{candidate: pix.candidate, direction: pix.direction};
	end

	// Retire the held pixel when it has no result or the result register has room for it
	assign commit    = valid_s1 && (!stage_s1.emit || res_free);
	assign pix_stall = valid_s1 && !commit;
	assign accept    = pix_valid && !pix_stall;
	assign rd_addr   = c_cur;

	// Hold configuration, counters and the stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= w_val;
					REG_IMAGE_HEIGHT: height_q <= h_val;
				endcase
			end
			if (accept) begin
				col_q    <= col_next;
				row_q    <= row_next;
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Capture the pixel payload
	always_ff @(posedge clk) begin
		if (accept)
			stage_s1 <= stage_d;
	end

endmodule

`default_nettype wire

>>> src/dnms_linebuf.sv
`default_nettype none

module dnms_linebuf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [dnms_pkg::COL_BITS-1:0] rd_addr,
	input  logic                          wr_en,
	input  logic [dnms_pkg::COL_BITS-1:0] wr_addr,
	input  dnms_pkg::line_word_t          wr_data,
	output dnms_pkg::line_word_t          rd_word
);
	import dnms_pkg::*;

	line_word_t mem [MAX_WIDTH];
	line_word_t rd_q;
	line_word_t byp_data_s1;
	logic       byp_s1;

	// Single write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Registered read; hold while the stage waits
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q        <= mem[rd_addr];
			byp_data_s1 <= wr_data;
		end
	end

	// Forward a write that lands on the entry being read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			byp_s1 <= 1'b0;
		else if (rd_en)
			byp_s1 <= wr_en && (wr_addr == rd_addr);
	end

	assign rd_word = byp_s1 ? byp_data_s1 : rd_q;

endmodule

`default_nettype wire

>>> src/dnms_window.sv
`default_nettype none

module dnms_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 commit,
	input  dnms_pkg::stage_t     stage_s1,
	input  dnms_pkg::line_word_t rd_word,
	output logic                 res_valid,
	input  logic                 res_stall,
	output dnms_pkg::res_t       res,
	output logic                 res_free
);
	import dnms_pkg::*;

	// Middle and right columns of the window; the left column is the
	// middle one before the shift
	logic [MAG_BITS-1:0] w01_q, w02_q, w11_q, w12_q, w21_q, w22_q;
	tag_t                held_q;
	logic [MAG_BITS-1:0] before_mag, after_mag;
	logic                dir_ok, edge_d;
	logic                res_valid_q;

	// Pick the neighbours along the centre's direction after the shift
	always_comb begin
		before_mag = '0;
		after_mag  = '0;
		dir_ok     = 1'b1;
		case (held_q.direction)
			DIR_H: begin
				before_mag = w11_q;
				after_mag  = rd_word.mag_a;
			end
			DIR_D45: begin
				before_mag = w01_q;
				after_mag  = stage_s1.mag;
			end
			DIR_V: begin
				before_mag = w02_q;
				after_mag  = w22_q;
			end
			DIR_D135: begin
				before_mag = rd_word.mag_b;
				after_mag  = w21_q;
			end
			default: dir_ok = 1'b0;
		endcase
		edge_d = held_q.candidate && dir_ok
			&& (before_mag <= w12_q) && (w12_q > after_mag);
	end

	// Shift the window and advance the centre tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w01_q  <= '0;
			w02_q  <= '0;
			w11_q  <= '0;
			w12_q  <= '0;
			w21_q  <= '0;
			w22_q  <= '0;
			held_q <= '0;
		end else if (commit && stage_s1.active) begin
			w01_q  <= w02_q;
			w11_q  <= w12_q;
			w21_q  <= w22_q;
			w02_q  <= rd_word.mag_b;
			w12_q  <= rd_word.mag_a;
			w22_q  <= stage_s1.mag;
			held_q <= rd_word.tag;
		end
	end

	// Result register: load when a pixel with a result commits, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (commit && stage_s1.emit)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit && stage_s1.emit) begin
			res.out_row    <= stage_s1.out_row;
			res.out_col    <= stage_s1.out_col;
			res.edge_res   <= edge_d;
			res.last_pixel <= stage_s1.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_free  = !res_valid_q || !res_stall;

endmodule

`default_nettype wire

>>> src/dnms_checker.sv
`default_nettype none

module dnms_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               pix_valid,
	input logic                               pix_stall,
	input logic                               res_valid,
	input logic                               res_stall,
	input dnms_pkg::res_t                     res
);
	import dnms_pkg::*;

	// A stalled result transaction holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// Input backs up only behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("pixel stalled without a stalled result");

	// A fresh result comes from an earlier taken pixel
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pix_valid && !pix_stall, 2))
		else $error("result without a matching pixel");

	// Only interior centres are reported
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.out_row != '0) && (res.out_col != '0))
		else $error("border pixel reported");

endmodule

bind directional_nonmax_suppression dnms_checker u_dnms_checker (.*);

`default_nettype wire

>>> test/directional_nonmax_suppression_test.sv
`timescale 1ns / 100ps

module directional_nonmax_suppression_test;
	import dnms_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int RESET_CYCLES = 9;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 500_000;
	localparam int RESET_PIXELS = 40;
	localparam int WIDE_PIXELS = 40;
	localparam int TALL_PIXELS = 60;
	localparam int FRAMES_GOAL = 250;

	// Direction codes outside the four compass directions
	localparam logic [DIR_BITS-1:0] DIR_NONE   = 3'd4;
	localparam logic [DIR_BITS-1:0] DIR_UNUSED = 3'd7;

	typedef struct {
		pix_t px;
		bit   typed;
		res_t want;
	} dir_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                     pix_valid = 1'b0;
	logic                     pix_stall;
	pix_t                     pix = '0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	res_t                     res;

	// Edge thinning mirror: registers, line buffers, window and counters
	bit [W_BITS-1:0]   width_reg = WIDTH_RESET;
	bit [ROW_BITS-1:0] height_reg = HEIGHT_RESET;
	bit [MAG_BITS-1:0] mag_line_a [MAX_WIDTH];
	bit [MAG_BITS-1:0] mag_line_b [MAX_WIDTH];
	tag_t              tag_line [MAX_WIDTH];
	bit [MAG_BITS-1:0] win [3][3];
	tag_t              held_tag = '0;
	int unsigned       row_cnt = 0;
	int unsigned       col_cnt = 0;

	res_t        pending_edges[$];
	dir_row_t    dir_rows[$];
	int unsigned snd_idle_pct = 0;
	int unsigned rcv_stall_pct = 0;
	bit          res_hold_req = 1'b0;
	int          frame_pixels = 0;
	int          fail_count = 0;
	int          cycle_count = 0;

	directional_nonmax_suppression i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int unsigned eff_width();
		if (width_reg < MIN_DIM) return MIN_DIM;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg < MIN_DIM) return MIN_DIM;
		return 32'(height_reg);
	endfunction

	// Advance the mirror by one pixel; return 1 when an interior centre is reported
	function automatic bit predict_edge(input pix_t px, output res_t r);
		int unsigned w, h, rr, cc;
		int k;
		bit [COL_BITS-1:0] ci;
		bit [MAG_BITS-1:0] above, above2, lo, hi;
		tag_t centre_tag, above_tag;
		bit has_dir;
		w = eff_width();
		h = eff_height();
		r = '0;
		if (px.frame_start) begin
			row_cnt = 0;
			col_cnt = 0;
		end
		if (col_cnt >= w) col_cnt = 0;
		rr = row_cnt;
		cc = col_cnt;
		// past the frame end: only the column moves
		if (rr >= h) begin
			col_cnt = (cc + 1 >= w) ? 0 : cc + 1;
			return 1'b0;
		end
		ci = COL_BITS'(cc);
		above = mag_line_a[ci];
		above2 = mag_line_b[ci];
		above_tag = tag_line[ci];
		mag_line_b[ci] = above;
		mag_line_a[ci] = px.magnitude;
		tag_line[ci] = '{px.candidate, px.direction};
		for (k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = above2;
		win[1][2] = above;
		win[2][2] = px.magnitude;
		centre_tag = held_tag;
		held_tag = above_tag;
		col_cnt = cc + 1;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt = rr + 1;
		end
		if (rr < 2 || cc < 2) return 1'b0;
		// pick the two neighbours along the gradient
		has_dir = 1'b1;
		lo = '0;
		hi = '0;
		case (centre_tag.direction)
			DIR_H: begin
				lo = win[1][0];
				hi = win[1][2];
			end
			DIR_D45: begin
				lo = win[0][0];
				hi = win[2][2];
			end
			DIR_V: begin
				lo = win[0][1];
				hi = win[2][1];
			end
			DIR_D135: begin
				lo = win[0][2];
				hi = win[2][0];
			end
			default: has_dir = 1'b0;
		endcase
		r.out_row = ROW_BITS'(rr - 1);
		r.out_col = COL_BITS'(cc - 1);
		r.edge_res = centre_tag.candidate && has_dir && lo <= win[1][1] && win[1][1] > hi;
		r.last_pixel = (rr == h - 1) && (cc == w - 1);
		return 1'b1;
	endfunction

	function automatic pix_t rand_pixel(input bit first);
		pix_t px;
		px.frame_start = first;
		px.candidate = ($urandom_range(3) != 0);
		// small magnitudes make ties and local maxima common
		case ($urandom_range(3))
			0, 1: px.magnitude = MAG_BITS'($urandom_range(7));
			2: px.magnitude = MAG_BITS'($urandom);
			default: px.magnitude = $urandom_range(1) ? '1 : '0;
		endcase
		if ($urandom_range(4) != 0) px.direction = DIR_BITS'($urandom_range(3));
		else px.direction = DIR_BITS'($urandom_range(7));
		return px;
	endfunction

	function automatic bit [CFG_DATA_BITS-1:0] pick_dim(input int unsigned top);
		if ($urandom_range(9) == 0) return CFG_DATA_BITS'($urandom_range(2));
		return CFG_DATA_BITS'($urandom_range(top, MIN_DIM));
	endfunction

	// Offer one pixel and record what it should produce once taken
	task automatic send_pixel(input pix_t px, input bit typed, input res_t want);
		res_t predicted;
		bit has_res;
		while ($urandom_range(99) < snd_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= px;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		has_res = predict_edge(px, predicted);
		if (typed) pending_edges.insert(pending_edges.size(), want);
		else if (has_res) pending_edges.insert(pending_edges.size(), predicted);
	endtask

	// Stop offering and wait until every result is in and the pipeline is quiet
	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending_edges.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame_size(input bit [CFG_DATA_BITS-1:0] w_raw,
			input bit [CFG_DATA_BITS-1:0] h_raw);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= w_raw;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= h_raw;
		@(posedge clk);
		cfg_write <= 1'b0;
		width_reg = w_raw[W_BITS-1:0];
		height_reg = h_raw;
	endtask

	// One frame of random content: mostly whole, sometimes cut short or overrun
	task automatic random_frame(input bit whole, input int pause_at);
		int total, extra, n, kind;
		total = eff_width() * eff_height();
		extra = 0;
		kind = whole ? 9 : $urandom_range(9);
		if (kind == 0) total = $urandom_range(total - 1, 1);
		else if (kind == 1) extra = $urandom_range(4, 1);
		for (n = 0; n < total; n++) begin
			if (n == pause_at) begin
				pix_valid <= 1'b0;
				@(posedge clk);
				while (pending_edges.size() != 0) @(posedge clk);
			end
			send_pixel(rand_pixel(n == 0), 1'b0, '0);
			frame_pixels++;
		end
		repeat (extra) send_pixel(rand_pixel(1'b0), 1'b0, '0);
	endtask

	task automatic small_frames(input int goal);
		int stop;
		stop = frame_pixels + goal;
		while (frame_pixels < stop) begin
			if ($urandom_range(2) == 0) set_frame_size(pick_dim(12), pick_dim(8));
			random_frame(1'b0, -1);
		end
	endtask

	task automatic add_row(input bit fs, input bit cand, input bit [MAG_BITS-1:0] mag,
			input bit [DIR_BITS-1:0] dir, input bit typed = 1'b0, input res_t want = '0);
		dir_row_t row;
		row.px = '{fs, cand, mag, dir};
		row.typed = typed;
		row.want = want;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// Receiver: random stalls, or one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (res_hold_req) begin
				res_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each result transaction with the oldest pending one
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_edges.size() == 0) begin
				$error("unexpected result: row %0d col %0d", res.out_row, res.out_col);
				fail_count++;
			end else begin
				want = pending_edges.pop_front();
				check_field("out_row", 16'(want.out_row), 16'(res.out_row));
				check_field("out_col", 16'(want.out_col), 16'(res.out_col));
				check_field("edge_res", 16'(want.edge_res), 16'(res.edge_res));
				check_field("last_pixel", 16'(want.last_pixel), 16'(res.last_pixel));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int n;

		// 3 x 7 frame: one interior column, one direction per row
		// row 0
		add_row(1'b1, 1'b0, 16'd0, DIR_NONE);
		add_row(1'b0, 1'b1, 16'hFFFF, DIR_H);
		add_row(1'b0, 1'b0, 16'd100, DIR_V);
		// row 1: horizontal centre ties its left neighbour
		add_row(1'b0, 1'b1, 16'hFFFF, DIR_H);
		add_row(1'b0, 1'b1, 16'hFFFF, DIR_H);
		add_row(1'b0, 1'b0, 16'd0, DIR_NONE);
		// row 2: centre at (1,1) is kept
		add_row(1'b0, 1'b0, 16'd10, DIR_H);
		add_row(1'b0, 1'b1, 16'd20, DIR_D45);
		add_row(1'b0, 1'b0, 16'd30, DIR_H, 1'b1, res_t'{12'd1, 10'd1, 1'b1, 1'b0});
		// row 3
		add_row(1'b0, 1'b0, 16'd5, DIR_H);
		add_row(1'b0, 1'b1, 16'd20, DIR_V);
		add_row(1'b0, 1'b0, 16'd7, DIR_H);
		// row 4
		add_row(1'b0, 1'b0, 16'd3, DIR_V);
		add_row(1'b0, 1'b1, 16'd19, DIR_D135);
		add_row(1'b0, 1'b0, 16'd2, DIR_H);
		// row 5: unused direction code on the last interior centre
		add_row(1'b0, 1'b0, 16'd19, DIR_H);
		add_row(1'b0, 1'b1, 16'hFFFF, DIR_UNUSED);
		add_row(1'b0, 1'b1, 16'd1, DIR_D45);
		// row 6: bottom border, reports the last centre
		add_row(1'b0, 1'b1, 16'd0, DIR_H);
		add_row(1'b0, 1'b0, 16'd0, DIR_V);
		add_row(1'b0, 1'b0, 16'd0, DIR_NONE, 1'b1, res_t'{12'd5, 10'd1, 1'b0, 1'b1});
		// past the frame end: ignored
		add_row(1'b0, 1'b1, 16'hFFFF, DIR_H);
		add_row(1'b0, 1'b1, 16'd0, DIR_D135);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 9;
		rcv_stall_pct = 75;

		// reset sizes: part of the first row, nothing is reported
		for (n = 0; n < RESET_PIXELS; n++)
			send_pixel(rand_pixel(n == 0), 1'b0, '0);

		// width below range clamps to the minimum
		set_frame_size(12'd0, 12'd7);
		foreach (dir_rows[i])
			send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);

		// long receiver hold-off while pixels keep coming
		set_frame_size(12'd10, 12'd8);
		res_hold_req = 1'b1;
		random_frame(1'b1, -1);
		// sender pauses mid-frame until all results are in
		random_frame(1'b1, 30);
		small_frames(FRAMES_GOAL);

		snd_idle_pct = 75;
		rcv_stall_pct = 9;
		// bit 11 of the data does not reach the width register
		set_frame_size(12'h805, 12'd4);
		random_frame(1'b1, -1);
		small_frames(FRAMES_GOAL);

		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		// height below range clamps to the minimum
		set_frame_size(12'd4, 12'd1);
		random_frame(1'b1, -1);
		// width above range clamps to the top; part of the first row only
		set_frame_size(12'h7FF, 12'd1);
		for (n = 0; n < WIDE_PIXELS; n++)
			send_pixel(rand_pixel(n == 0), 1'b0, '0);
		// tallest frame, cut short well before its end
		set_frame_size(12'd3, 12'hFFF);
		for (n = 0; n < TALL_PIXELS; n++)
			send_pixel(rand_pixel(n == 0), 1'b0, '0);
		small_frames(FRAMES_GOAL);

		drain();
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
src/dnms_pkg.sv
src/dnms_ctrl.sv
src/dnms_linebuf.sv
src/dnms_window.sv
src/directional_nonmax_suppression.sv
src/dnms_checker.sv
test/directional_nonmax_suppression_test.sv
